// ----- rtl/spq_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_pkg: shared types and codes for the stable priority queue
// Holds the operation and status codes and the per-cycle control bundle
// that drives the row of storage cells.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam logic FUNC_ENQ = 1'b0;
	localparam logic FUNC_DEQ = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic enq;
		logic deq;
	} spq_ctl_t;

endpackage : spq_pkg
`default_nettype wire

// ----- rtl/stable_priority_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue: sorted priority queue with stable ties
// A row of cells kept in priority order, head in cell 0. Insert and remove
// each complete in the cycle the word is accepted.
// ----------------------------------------------------------------------------
// The result word is registered and appears on the master side in the cycle
// after the input word is accepted.
// Throughput: one word per cycle; every cell compares and shifts in parallel.
// A new word is taken while the result register is empty or being drained.
// Reset clears the entry count and the result valid; cell contents are left
// as they are and are never read before written.
module stable_priority_queue
	import spq_pkg::*;
#(
	parameter int CAPACITY   = 16,
	parameter int DATA_WIDTH = 16,
	parameter int PRIO_WIDTH = 8,
	localparam int CW  = $clog2(CAPACITY + 1),
	localparam int SW  = ((DATA_WIDTH + PRIO_WIDTH + 7) / 8) * 8,
	localparam int MW  = ((DATA_WIDTH + PRIO_WIDTH + CW + 7) / 8) * 8
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           s_tvalid,
	output logic          s_tready,
	// data_value, priority_value
	input  wire  [SW-1:0] s_tdata,
	// func
	input  wire           s_tuser,
	output logic          m_tvalid,
	input  wire           m_tready,
	// out_data, out_priority, occupancy
	output logic [MW-1:0] m_tdata,
	// status
	output logic [1:0]    m_tuser
);

	logic [CW-1:0]         count_q;
	logic [CW-1:0]         count_d;
	logic                  s_accept;
	logic                  is_full;
	logic                  is_empty;
	spq_ctl_t              ctl;
	logic [DATA_WIDTH-1:0] new_data;
	logic [PRIO_WIDTH-1:0] new_prio;

	logic                  m_valid_q;
	logic [DATA_WIDTH-1:0] m_data_q;
	logic [PRIO_WIDTH-1:0] m_prio_q;
	logic [CW-1:0]         m_occ_q;
	logic [1:0]            m_status_q;
	logic [1:0]            status_d;

	logic                  shift_w [CAPACITY];
	logic [DATA_WIDTH-1:0] data_w  [CAPACITY];
	logic [PRIO_WIDTH-1:0] prio_w  [CAPACITY];

	assign new_data = s_tdata[DATA_WIDTH-1:0];
	assign new_prio = s_tdata[DATA_WIDTH +: PRIO_WIDTH];

	assign s_tready = !m_valid_q || m_tready;
	assign s_accept = s_tvalid && s_tready;
	assign is_full  = (count_q == CW'(CAPACITY));
	assign is_empty = (count_q == '0);

	always_comb begin
		ctl.enq  = s_accept && (s_tuser == FUNC_ENQ) && !is_full;
		ctl.deq  = s_accept && (s_tuser == FUNC_DEQ) && !is_empty;
		count_d  = count_q;
		status_d = ST_OK;
		if (ctl.enq) begin
			count_d = count_q + CW'(1);
		end else if (ctl.deq) begin
			count_d = count_q - CW'(1);
		end
		if (s_tuser == FUNC_ENQ && is_full) begin
			status_d = ST_FULL;
		end else if (s_tuser == FUNC_DEQ && is_empty) begin
			status_d = ST_EMPTY;
		end
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic                  l_shift;
		logic [DATA_WIDTH-1:0] l_data;
		logic [PRIO_WIDTH-1:0] l_prio;
		logic [DATA_WIDTH-1:0] r_data;
		logic [PRIO_WIDTH-1:0] r_prio;

		if (i == 0) begin : g_head
			assign l_shift = 1'b0;
			assign l_data  = '0;
			assign l_prio  = '0;
		end else begin : g_mid
			assign l_shift = shift_w[i-1];
			assign l_data  = data_w[i-1];
			assign l_prio  = prio_w[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign r_data = '0;
			assign r_prio = '0;
		end else begin : g_body
			assign r_data = data_w[i+1];
			assign r_prio = prio_w[i+1];
		end

		spq_cell #(
			.DATA_WIDTH(DATA_WIDTH),
			.PRIO_WIDTH(PRIO_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.live       (count_q > CW'(i)),
			.in_data    (new_data),
			.in_prio    (new_prio),
			.left_shift (l_shift),
			.left_data  (l_data),
			.left_prio  (l_prio),
			.right_data (r_data),
			.right_prio (r_prio),
			.shift      (shift_w[i]),
			.data       (data_w[i]),
			.prio       (prio_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			m_valid_q <= 1'b0;
		end else begin
			count_q <= count_d;
			if (s_accept) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_accept) begin
			m_data_q   <= ctl.deq ? data_w[0] : '0;
			m_prio_q   <= ctl.deq ? prio_w[0] : '0;
			m_occ_q    <= count_d;
			m_status_q <= status_d;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = MW'({m_occ_q, m_prio_q, m_data_q});
	assign m_tuser  = m_status_q;

	// The count never runs past the number of cells.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// A removal from a non-empty queue yields an ok word with one fewer entry.
	a_deq_ok: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_tuser == FUNC_DEQ) && !is_empty |=>
		m_valid_q && (m_status_q == ST_OK) && (m_occ_q == count_q))
		else $error("dequeue result mismatch");

	// An insert on a full queue leaves the count as it was.
	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		s_accept && (s_tuser == FUNC_ENQ) && is_full |=>
		(count_q == CW'(CAPACITY)) && (m_status_q == ST_FULL))
		else $error("full insert changed the queue");

	// The two cells nearest the head stay in priority order.
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q >= CW'(2)) |-> (prio_w[0] >= prio_w[1]))
		else $error("head cells out of order");

endmodule : stable_priority_queue
`default_nettype wire

// ----- rtl/spq_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted queue
// Keeps its entry, takes the neighbor toward the head, or takes the new
// entry on an insert; takes the neighbor toward the tail on a removal.
// ----------------------------------------------------------------------------
module spq_cell
	import spq_pkg::*;
#(
	parameter int DATA_WIDTH = 16,
	parameter int PRIO_WIDTH = 8
) (
	input  wire                   clk,
	input  spq_ctl_t              ctl,
	input  wire                   live,
	input  wire  [DATA_WIDTH-1:0] in_data,
	input  wire  [PRIO_WIDTH-1:0] in_prio,
	input  wire                   left_shift,
	input  wire  [DATA_WIDTH-1:0] left_data,
	input  wire  [PRIO_WIDTH-1:0] left_prio,
	input  wire  [DATA_WIDTH-1:0] right_data,
	input  wire  [PRIO_WIDTH-1:0] right_prio,
	output logic                  shift,
	output logic [DATA_WIDTH-1:0] data,
	output logic [PRIO_WIDTH-1:0] prio
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [PRIO_WIDTH-1:0] prio_q;

	// An entry stays put only if it is held and its priority is not below the
	// new one, which keeps arrival order among equal priorities.
	assign shift = !(live && (prio_q >= in_prio));
	assign data  = data_q;
	assign prio  = prio_q;

	always_ff @(posedge clk) begin
		if (ctl.enq && shift) begin
			data_q <= left_shift ? left_data : in_data;
			prio_q <= left_shift ? left_prio : in_prio;
		end else if (ctl.deq) begin
			data_q <= right_data;
			prio_q <= right_prio;
		end
	end

endmodule : spq_cell
`default_nettype wire

// ----- bench/stable_priority_queue_test.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// stable_priority_queue_test: self-checking bench for the stable priority queue
// Drives insert and remove words through the slave side and keeps its own
// sorted copy of the queue. Every result word is checked field by field, in
// order, against the copy's prediction. Directed cases cover empty and full
// queues, ties and field extremes, then long random traffic with bursty
// input and a stalling output side.
// ----------------------------------------------------------------------------
module stable_priority_queue_test;
	import spq_pkg::*;

	localparam int CAPACITY    = 16;
	localparam int DATA_WIDTH  = 16;
	localparam int PRIO_WIDTH  = 8;
	localparam int SW          = 24;
	localparam int MW          = 32;
	localparam int CYCLE_LIMIT = 400000;
	localparam int RANDOM_OPS  = 1500;
	localparam int MAX_REPORTS = 40;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] data;
		logic [PRIO_WIDTH-1:0] prio;
		logic [1:0]            status;
		logic [4:0]            occupancy;
	} pq_result_t;

	typedef enum int {RX_ALWAYS, RX_COIN, RX_PERIODIC, RX_SPARSE} rx_style_t;

	logic          clk      = 1'b0;
	logic          arst_n   = 1'b0;
	logic          s_tvalid = 1'b0;
	logic          s_tready;
	logic [SW-1:0] s_tdata  = '0;
	logic          s_tuser  = FUNC_ENQ;
	logic          m_tvalid;
	logic          m_tready = 1'b0;
	logic [MW-1:0] m_tdata;
	logic [1:0]    m_tuser;

	// Sorted copy of the queue, head in slot 0.
	logic [DATA_WIDTH-1:0] held_data [CAPACITY];
	logic [PRIO_WIDTH-1:0] held_prio [CAPACITY];
	int                    held_count = 0;

	pq_result_t pending_results[$];
	int         error_count  = 0;
	int         cycle_count  = 0;
	int         burst_left   = 0;
	bit         steady_send  = 1'b1;
	rx_style_t  rx_style     = RX_ALWAYS;
	int         rx_left      = 0;
	int         rx_phase     = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stable_priority_queue #(
		.CAPACITY  (CAPACITY),
		.DATA_WIDTH(DATA_WIDTH),
		.PRIO_WIDTH(PRIO_WIDTH)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	// Applies one operation to the sorted copy and returns the result word it
	// should produce. A new entry lands after every held entry of equal priority.
	function automatic pq_result_t queue_apply(logic op, logic [DATA_WIDTH-1:0] d,
			logic [PRIO_WIDTH-1:0] p);
		pq_result_t r;
		int         pos;
		int         k;
		r = '0;
		r.status = ST_OK;
		if (op == FUNC_ENQ) begin
			if (held_count >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				pos = 0;
				while (pos < held_count && held_prio[pos] >= p)
					pos++;
				for (k = held_count; k > pos; k--) begin
					held_data[k] = held_data[k-1];
					held_prio[k] = held_prio[k-1];
				end
				held_data[pos] = d;
				held_prio[pos] = p;
				held_count++;
			end
		end else begin
			if (held_count == 0) begin
				r.status = ST_EMPTY;
			end else begin
				r.data = held_data[0];
				r.prio = held_prio[0];
				for (k = 1; k < held_count; k++) begin
					held_data[k-1] = held_data[k];
					held_prio[k-1] = held_prio[k];
				end
				held_count--;
			end
		end
		r.occupancy = held_count[4:0];
		return r;
	endfunction

	// Inserts a random gap between bursts unless the sender is in a steady run.
	task automatic pace_sender();
		int gap;
		if (steady_send)
			return;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			gap = $urandom_range(1, 6);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
			burst_left = $urandom_range(1, 24);
		end
	endtask

	// Called at a falling edge; returns at a falling edge after the word is taken.
	task automatic send_word(input logic op, input logic [DATA_WIDTH-1:0] d,
			input logic [PRIO_WIDTH-1:0] p);
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= {p, d};
		do
			@(posedge clk);
		while (!s_tready);
		pending_results.push_back(queue_apply(op, d, p));
		@(negedge clk);
		pace_sender();
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		do
			@(negedge clk);
		while (pending_results.size() != 0);
	endtask

	task automatic report_mismatch(input string field, input int want, input int got);
		error_count++;
		if (error_count <= MAX_REPORTS)
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
	endtask

	// Output stall pattern: picks a new random style at the end of each run.
	always @(negedge clk) begin
		if (rx_left == 0) begin
			rx_style = rx_style_t'($urandom_range(0, 3));
			rx_left  = $urandom_range(16, 120);
		end else begin
			rx_left--;
		end
		rx_phase++;
		case (rx_style)
			RX_ALWAYS:   m_tready <= 1'b1;
			RX_COIN:     m_tready <= 1'($urandom_range(0, 1));
			RX_PERIODIC: m_tready <= (rx_phase % 3 != 0);
			default:     m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	always @(posedge clk) begin
		pq_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				error_count++;
				if (error_count <= MAX_REPORTS)
					$display("%0t: unexpected result word, expected none, actual %0h/%0h",
						$time, m_tdata, m_tuser);
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[15:0] !== want.data)
					report_mismatch("out_data", int'(want.data), int'(m_tdata[15:0]));
				if (m_tdata[23:16] !== want.prio)
					report_mismatch("out_priority", int'(want.prio), int'(m_tdata[23:16]));
				if (m_tdata[28:24] !== want.occupancy)
					report_mismatch("occupancy", int'(want.occupancy),
						int'(m_tdata[28:24]));
				if (m_tuser !== want.status)
					report_mismatch("status", int'(want.status), int'(m_tuser));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// Empty queue, field extremes and first-in order among equal priorities.
	task automatic test_empty_and_ties();
		send_word(FUNC_DEQ, 16'hFFFF, 8'hFF);
		send_word(FUNC_ENQ, 16'h0000, 8'h00);
		send_word(FUNC_ENQ, 16'hFFFF, 8'hFF);
		send_word(FUNC_ENQ, 16'hA5A5, 8'hFF);
		send_word(FUNC_ENQ, 16'h5A5A, 8'h00);
		send_word(FUNC_DEQ, 16'h0000, 8'h00);
		send_word(FUNC_DEQ, 16'hFFFF, 8'hFF);
		send_word(FUNC_DEQ, 16'h1234, 8'h80);
		send_word(FUNC_DEQ, 16'h0000, 8'h00);
		send_word(FUNC_DEQ, 16'h0000, 8'h00);
	endtask

	// Fills every slot with clustered priorities, then tries one more insert and removes the head.
	task automatic test_fill_past_capacity();
		int i;
		for (i = 0; i < CAPACITY; i++)
			send_word(FUNC_ENQ, DATA_WIDTH'($urandom_range(0, 65535)),
				PRIO_WIDTH'($urandom_range(0, 3) * 85));
		send_word(FUNC_ENQ, 16'hFFFF, 8'hFF);
		send_word(FUNC_DEQ, 16'h0000, 8'h00);
	endtask

	// Segments of random traffic, each with its own insert/remove mix and
	// priority spread, so the queue swings between empty and full.
	task automatic test_random_traffic();
		int  sent;
		int  seg_len;
		int  enq_pct;
		int  prio_mode;
		int  i;
		bit  paused;
		logic op;
		logic [DATA_WIDTH-1:0] d;
		logic [PRIO_WIDTH-1:0] p;
		sent   = 0;
		paused = 1'b0;
		while (sent < RANDOM_OPS) begin
			seg_len   = $urandom_range(20, 120);
			case ($urandom_range(0, 2))
				0:       enq_pct = 85;
				1:       enq_pct = 50;
				default: enq_pct = 15;
			endcase
			prio_mode   = $urandom_range(0, 2);
			steady_send = ($urandom_range(0, 3) == 0);
			for (i = 0; i < seg_len; i++) begin
				op = ($urandom_range(0, 99) < enq_pct) ? FUNC_ENQ : FUNC_DEQ;
				d  = ($urandom_range(0, 15) == 0) ? {DATA_WIDTH{$urandom_range(0, 1) == 1}}
					: DATA_WIDTH'($urandom_range(0, 65535));
				case (prio_mode)
					0:       p = PRIO_WIDTH'($urandom_range(0, 255));
					1:       p = PRIO_WIDTH'($urandom_range(0, 3));
					default: p = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
				endcase
				send_word(op, d, p);
			end
			sent += seg_len;
			// Let the queue drain its results once with the input held off.
			if (!paused && sent >= RANDOM_OPS / 2) begin
				wait_drained();
				paused = 1'b1;
			end
		end
	endtask

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_empty_and_ties();
		test_fill_past_capacity();
		test_random_traffic();
		wait_drained();
		repeat (4) @(negedge clk);
		if (error_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule : stable_priority_queue_test
`default_nettype wire

// ----- filelist.f -----
rtl/spq_pkg.sv
rtl/spq_cell.sv
rtl/stable_priority_queue.sv
bench/stable_priority_queue_test.sv
